>>> src/efp_pkg.sv
// Shared types, character constants and helpers for the eISCP frame parser.
// No dependencies; imported by eiscp_frame_parser_top.
`timescale 1ns / 1ps
`default_nettype none

package efp_pkg;

    // Parse phase; the unused code falls back to hunting.
    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_PAYLOAD = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_VOLUME   = 3'd1,
        EV_POWER_ON = 3'd2,
        EV_STANDBY  = 3'd3,
        EV_BAD_HDR  = 3'd4,
        EV_TOO_LONG = 3'd5
    } t_event;

    typedef enum logic [1:0] {
        PWR_NONE = 2'd0,
        PWR_ON   = 2'd1,
        PWR_STBY = 2'd2
    } t_power;

    localparam int unsigned CFG_W    = 13;
    localparam int unsigned WIN_LEN  = 10;
    localparam int unsigned WIN_W    = WIN_LEN * 8;

    localparam logic [31:0]      MAGIC_WORD  = 32'h4953_4350;  // "ISCP"
    localparam logic [31:0]      HDR_LEN     = 32'd16;
    localparam logic [CFG_W-1:0] MAX_LEN_RST = 13'd4096;
    localparam logic [7:0]       VOL_LIMIT   = 8'd200;

    // Header byte positions that close a field.
    localparam logic [3:0] POS_HDR_LEN = 4'd3;
    localparam logic [3:0] POS_PAY_LEN = 4'd7;
    localparam logic [3:0] POS_LAST    = 4'd11;

    localparam logic [23:0] STR_MVL     = "MVL";
    localparam logic [23:0] STR_PWR     = "PWR";
    localparam logic [15:0] STR_01      = "01";
    localparam logic [15:0] STR_ON      = "ON";
    localparam logic [15:0] STR_00      = "00";
    localparam logic [47:0] STR_PWROFF  = "PWROFF";
    localparam logic [79:0] STR_PWRSTBY = "PWRSTANDBY";

    // Hex digit value, either case; 16 marks a non-digit.
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] v;
        v = 5'd16;
        if (c inside {[8'h30:8'h39]}) begin
            v = {1'b0, 4'(c - 8'h30)};
        end else if (c inside {[8'h41:8'h46]}) begin
            v = {1'b0, 4'(c - 8'h37)};
        end else if (c inside {[8'h61:8'h66]}) begin
            v = {1'b0, 4'(c - 8'h57)};
        end
        return v;
    endfunction

endpackage

`default_nettype wire

>>> src/eiscp_frame_parser_top.sv
// eISCP frame parser top level: input register, single-pass parse logic,
// result register. Depends on efp_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Byte-stream parser for eISCP frames. Takes one byte transaction per clock
// (restart=1 clears all parsing and gives no result). Hunts for "ISCP" in a
// sliding 4-byte window, checks the 16-byte header (header length must be 16,
// payload length must not exceed the r_max_len config register), then scans
// the payload through a 10-byte window for MVLxx volume and PWR power reports.
// One result transaction comes per finished or dropped frame. Throughput is
// one byte per clock while the result side does not stall: each byte waits in
// the input register, and the whole parse step runs between that register and
// the result register, which takes the result when the input register moves on.
// Backpressure on the result side stalls the input register; o_in_ready stays
// high while the input register is empty or moving on in the same cycle.
// The config register (reset 4096) may only be written while the block is idle.
module eiscp_frame_parser_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // config
    input  wire logic        i_cfg_we,
    input  wire logic [12:0] i_cfg_data,
    // byte input channel
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_restart,
    // result channel
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [2:0]       o_event_kind,
    output logic [7:0]       o_volume_level
);
    import efp_pkg::*;

    // ---------------- registers ----------------
    logic [CFG_W-1:0] r_max_len;

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_in_restart;

    t_phase           r_phase,      n_phase;
    logic [31:0]      r_magic,      n_magic;
    logic [3:0]       r_hdr_pos,    n_hdr_pos;
    logic [31:0]      r_hdr_word,   n_hdr_word;
    logic [CFG_W-1:0] r_pay_len,    n_pay_len;
    logic [CFG_W-1:0] r_pay_pos,    n_pay_pos;
    logic [WIN_W-1:0] r_recent,     n_recent;   // byte 0 of the window at MSBs
    logic             r_vol_found,  n_vol_found;
    logic [7:0]       r_vol_value,  n_vol_value;
    t_power           r_power,      n_power;

    logic             r_out_valid;
    t_event           r_out_kind;
    logic [7:0]       r_out_vol;

    // ---------------- handshake ----------------
    logic proc_go;  // input register item is processed this cycle

    assign proc_go    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || proc_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LEN_RST;
        end else if (i_cfg_we) begin
            r_max_len <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte    <= i_data_byte;
            r_in_restart <= i_restart;
        end
    end

    // ---------------- parse step ----------------
    logic             emit;
    logic             frame_done;
    logic             clear_all;
    t_event           ev_kind;
    logic [7:0]       ev_vol;
    logic [4:0]       hex_hi, hex_lo;
    logic [7:0]       vol_cand;
    logic [CFG_W-1:0] pos_inc;

    always_comb begin
        n_phase     = r_phase;
        n_magic     = r_magic;
        n_hdr_pos   = r_hdr_pos;
        n_hdr_word  = r_hdr_word;
        n_pay_len   = r_pay_len;
        n_pay_pos   = r_pay_pos;
        n_recent    = r_recent;
        n_vol_found = r_vol_found;
        n_vol_value = r_vol_value;
        n_power     = r_power;
        emit        = 1'b0;
        frame_done  = 1'b0;
        clear_all   = 1'b0;
        ev_kind     = EV_NONE;
        ev_vol      = 8'd0;
        hex_hi      = 5'd16;
        hex_lo      = 5'd16;
        vol_cand    = 8'd0;
        pos_inc     = r_pay_pos + 1'b1;

        if (r_in_restart) begin
            clear_all = 1'b1;
        end else begin
            case (r_phase)
                PH_HEADER: begin
                    n_hdr_word = {r_hdr_word[23:0], r_in_byte};
                    n_hdr_pos  = r_hdr_pos + 1'b1;
                    if (r_hdr_pos == POS_HDR_LEN) begin
                        if (n_hdr_word != HDR_LEN) begin
                            emit      = 1'b1;
                            ev_kind   = EV_BAD_HDR;
                            clear_all = 1'b1;
                        end else begin
                            n_hdr_word = '0;
                        end
                    end else if (r_hdr_pos == POS_PAY_LEN) begin
                        if (n_hdr_word > {{(32-CFG_W){1'b0}}, r_max_len}) begin
                            emit      = 1'b1;
                            ev_kind   = EV_TOO_LONG;
                            clear_all = 1'b1;
                        end else begin
                            n_pay_len  = n_hdr_word[CFG_W-1:0];
                            n_hdr_word = '0;
                        end
                    end else if (r_hdr_pos >= POS_LAST) begin
                        if (r_pay_len == '0) begin
                            frame_done = 1'b1;
                        end else begin
                            n_phase     = PH_PAYLOAD;
                            n_pay_pos   = '0;
                            n_recent    = '0;
                            n_vol_found = 1'b0;
                            n_vol_value = 8'd0;
                            n_power     = PWR_NONE;
                        end
                    end
                end

                PH_PAYLOAD: begin
                    n_recent = {r_recent[WIN_W-9:0], r_in_byte};
                    hex_hi   = hex_val(n_recent[15:8]);
                    hex_lo   = hex_val(n_recent[7:0]);
                    vol_cand = {hex_hi[3:0], hex_lo[3:0]};
                    if (!r_vol_found && n_recent[39:16] == STR_MVL
                            && !hex_hi[4] && !hex_lo[4] && vol_cand <= VOL_LIMIT) begin
                        n_vol_found = 1'b1;
                        n_vol_value = vol_cand;
                    end
                    if (r_power == PWR_NONE) begin
                        if (n_recent[39:16] == STR_PWR
                                && (n_recent[15:0] == STR_01 || n_recent[15:0] == STR_ON)) begin
                            n_power = PWR_ON;
                        end else if (n_recent[39:16] == STR_PWR
                                && n_recent[15:0] == STR_00) begin
                            n_power = PWR_STBY;
                        end else if (n_recent[47:0] == STR_PWROFF) begin
                            n_power = PWR_STBY;
                        end else if (n_recent == STR_PWRSTBY) begin
                            n_power = PWR_STBY;
                        end
                    end
                    n_pay_pos = pos_inc;
                    if (pos_inc >= r_pay_len) begin
                        frame_done = 1'b1;
                    end
                end

                default: begin
                    // hunting (also the unused phase code)
                    n_phase = PH_HUNT;
                    n_magic = {r_magic[23:0], r_in_byte};
                    if (n_magic == MAGIC_WORD) begin
                        n_magic    = '0;
                        n_phase    = PH_HEADER;
                        n_hdr_pos  = '0;
                        n_hdr_word = '0;
                    end
                end
            endcase
        end

        if (frame_done) begin
            emit      = 1'b1;
            clear_all = 1'b1;
            if (n_vol_found) begin
                ev_kind = EV_VOLUME;
                ev_vol  = n_vol_value;
            end else if (n_power == PWR_ON) begin
                ev_kind = EV_POWER_ON;
            end else if (n_power == PWR_STBY) begin
                ev_kind = EV_STANDBY;
            end
        end

        if (clear_all) begin
            n_phase     = PH_HUNT;
            n_magic     = '0;
            n_hdr_pos   = '0;
            n_hdr_word  = '0;
            n_pay_len   = '0;
            n_pay_pos   = '0;
            n_recent    = '0;
            n_vol_found = 1'b0;
            n_vol_value = 8'd0;
            n_power     = PWR_NONE;
        end
    end

    // parse state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT;
            r_magic     <= '0;
            r_hdr_pos   <= '0;
            r_hdr_word  <= '0;
            r_pay_len   <= '0;
            r_pay_pos   <= '0;
            r_recent    <= '0;
            r_vol_found <= 1'b0;
            r_vol_value <= 8'd0;
            r_power     <= PWR_NONE;
        end else if (proc_go) begin
            r_phase     <= n_phase;
            r_magic     <= n_magic;
            r_hdr_pos   <= n_hdr_pos;
            r_hdr_word  <= n_hdr_word;
            r_pay_len   <= n_pay_len;
            r_pay_pos   <= n_pay_pos;
            r_recent    <= n_recent;
            r_vol_found <= n_vol_found;
            r_vol_value <= n_vol_value;
            r_power     <= n_power;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_go) begin
            r_out_valid <= emit;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_go && emit) begin
            r_out_kind <= ev_kind;
            r_out_vol  <= ev_vol;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_event_kind   = r_out_kind;
    assign o_volume_level = r_out_vol;

    // ---------------- assertions ----------------
    // volume field only carries data on a volume report
    a_vol_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_event_kind != EV_VOLUME |-> o_volume_level == 8'd0)
        else $error("volume level nonzero on non-volume result");

    a_vol_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_volume_level <= VOL_LIMIT)
        else $error("volume level above limit");

    // a restart transaction never yields a result
    a_restart_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc_go && r_in_restart |=> !r_out_valid)
        else $error("result after restart");

    // every result ends the frame and returns to hunting
    a_emit_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc_go && emit |=> r_phase == PH_HUNT && r_magic == '0)
        else $error("parser not hunting after result");

endmodule

`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for eiscp_frame_parser_top: a byte stream goes in, frame events
// are predicted in the bench and checked against the result channel.
// Depends on efp_pkg and eiscp_frame_parser_top.
`timescale 1ns / 1ps

module tb;
    import efp_pkg::*;

    localparam int unsigned CLK_PERIOD   = 12;
    localparam int unsigned IDLE_PCT     = 35;    // chance that a side idles in a cycle
    localparam int unsigned STALL_LIMIT  = 2000;  // cycles with no transaction at all
    localparam int unsigned DRAIN_CYCLES = 4;     // extra wait once the queues have drained

    // Frame layout and content limits
    localparam logic [31:0] MAGIC        = 32'h4953_4350;  // "ISCP"
    localparam logic [31:0] EXP_HDR_LEN  = 32'd16;
    localparam logic [3:0]  HDR_LEN_END  = 4'd3;           // byte closing header length
    localparam logic [3:0]  PAY_LEN_END  = 4'd7;           // byte closing payload length
    localparam logic [3:0]  HDR_END      = 4'd11;          // last header byte
    localparam int          VOL_MAX      = 200;

    typedef struct packed {
        logic [7:0] data;
        logic       restart;
    } t_byte_txn;

    typedef struct {
        t_event     kind;
        logic [7:0] level;
    } t_frame_event;

    // DUT signals; every input starts at a known value
    logic        i_clk;
    logic        i_rst_n        = 1'b0;
    logic        i_cfg_we       = 1'b0;
    logic [12:0] i_cfg_data     = '0;
    logic        i_in_valid     = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_data_byte    = '0;
    logic        i_restart      = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready    = 1'b0;
    logic [2:0]  o_event_kind;
    logic [7:0]  o_volume_level;

    eiscp_frame_parser_top u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_data_byte    (i_data_byte),
        .i_restart      (i_restart),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_event_kind   (o_event_kind),
        .o_volume_level (o_volume_level)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    t_byte_txn    byte_feed[$];        // byte transactions waiting for the driver
    t_frame_event expected_events[$];  // predicted result transactions, oldest first
    logic [7:0]   body[$];             // payload under construction

    int unsigned bytes_queued = 0;
    int unsigned bytes_taken  = 0;
    int unsigned results_seen = 0;
    int unsigned error_count  = 0;
    int unsigned idle_cycles  = 0;
    int unsigned kind_count[6];
    logic        steady       = 1'b0;  // set: neither side idles
    logic        in_took      = 1'b0;  // byte transaction accepted at the last rising edge

    // ------------------------------------------------------------------
    // Frame parser prediction
    // ------------------------------------------------------------------
    logic [12:0] max_len = MAX_LEN_RST;
    logic [31:0] hunt_window;
    t_phase      phase;
    logic [3:0]  hdr_pos;
    logic [31:0] hdr_word;
    logic [12:0] pay_len;
    logic [12:0] pay_pos;
    logic [79:0] tail;        // last ten payload bytes, newest in the low byte
    logic        vol_found;
    logic [7:0]  vol_value;
    t_power      pwr_seen;

    function automatic void clear_parse_state();
        hunt_window = '0;
        phase       = PH_HUNT;
        hdr_pos     = '0;
        hdr_word    = '0;
        pay_len     = '0;
        pay_pos     = '0;
        tail        = '0;
        vol_found   = 1'b0;
        vol_value   = '0;
        pwr_seen    = PWR_NONE;
    endfunction

    function automatic int hex_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c - "0");
        if (c >= "A" && c <= "F") return int'(c - "A") + 10;
        if (c >= "a" && c <= "f") return int'(c - "a") + 10;
        return -1;
    endfunction

    // Looks for volume and power reports ending at the newest payload byte.
    function automatic void scan_tail();
        int hi;
        int lo;
        if (!vol_found && tail[39:16] == "MVL") begin
            hi = hex_digit(tail[15:8]);
            lo = hex_digit(tail[7:0]);
            if (hi >= 0 && lo >= 0 && hi * 16 + lo <= VOL_MAX) begin
                vol_found = 1'b1;
                vol_value = 8'(hi * 16 + lo);
            end
        end
        if (pwr_seen == PWR_NONE) begin
            if (tail[39:16] == "PWR") begin
                if (tail[15:0] == "01" || tail[15:0] == "ON") begin
                    pwr_seen = PWR_ON;
                end else if (tail[15:0] == "00") begin
                    pwr_seen = PWR_STBY;
                end
            end
            if (pwr_seen == PWR_NONE && tail[47:0] == "PWROFF") pwr_seen = PWR_STBY;
            if (pwr_seen == PWR_NONE && tail == "PWRSTANDBY") pwr_seen = PWR_STBY;
        end
    endfunction

    function automatic t_frame_event frame_done(input t_event kind, input logic [7:0] level);
        t_frame_event ev;
        ev.kind  = kind;
        ev.level = level;
        clear_parse_state();
        return ev;
    endfunction

    // Volume beats power; power on beats standby only by coming first.
    function automatic t_frame_event frame_summary();
        if (vol_found) return frame_done(EV_VOLUME, vol_value);
        if (pwr_seen == PWR_ON) return frame_done(EV_POWER_ON, 8'd0);
        if (pwr_seen == PWR_STBY) return frame_done(EV_STANDBY, 8'd0);
        return frame_done(EV_NONE, 8'd0);
    endfunction

    task automatic parse_byte(input logic [7:0] b, input logic restart,
                              output logic hit, output t_frame_event ev);
        logic [3:0] pos;
        hit = 1'b0;
        ev  = '{EV_NONE, 8'd0};
        if (restart) begin
            clear_parse_state();
        end else if (phase == PH_HEADER) begin
            pos      = hdr_pos;
            hdr_word = {hdr_word[23:0], b};
            hdr_pos  = pos + 4'd1;
            if (pos == HDR_LEN_END) begin
                if (hdr_word != EXP_HDR_LEN) begin
                    hit = 1'b1;
                    ev  = frame_done(EV_BAD_HDR, 8'd0);
                end else begin
                    hdr_word = '0;
                end
            end else if (pos == PAY_LEN_END) begin
                if (hdr_word > 32'(max_len)) begin
                    hit = 1'b1;
                    ev  = frame_done(EV_TOO_LONG, 8'd0);
                end else begin
                    pay_len  = hdr_word[12:0];
                    hdr_word = '0;
                end
            end else if (pos >= HDR_END) begin
                if (pay_len == '0) begin
                    hit = 1'b1;
                    ev  = frame_summary();
                end else begin
                    phase     = PH_PAYLOAD;
                    pay_pos   = '0;
                    tail      = '0;
                    vol_found = 1'b0;
                    vol_value = '0;
                    pwr_seen  = PWR_NONE;
                end
            end
        end else if (phase == PH_PAYLOAD) begin
            tail = {tail[71:0], b};
            scan_tail();
            pay_pos = pay_pos + 13'd1;
            if (pay_pos >= pay_len) begin
                hit = 1'b1;
                ev  = frame_summary();
            end
        end else begin
            phase       = PH_HUNT;
            hunt_window = {hunt_window[23:0], b};
            if (hunt_window == MAGIC) begin
                hunt_window = '0;
                phase       = PH_HEADER;
                hdr_pos     = '0;
                hdr_word    = '0;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    task automatic push_byte(input logic [7:0] b, input logic restart);
        byte_feed.push_back('{data: b, restart: restart});
        bytes_queued++;
    endtask

    task automatic push_text(input string s);
        foreach (s[i]) push_byte(s[i], 1'b0);
    endtask

    task automatic add_text(input string s);
        foreach (s[i]) body.push_back(s[i]);
    endtask

    task automatic add_noise(input int unsigned n);
        repeat (n) body.push_back(8'($urandom));
    endtask

    // Magic, header and the current body; a restart goes in ahead of byte index cut.
    task automatic send_frame(input logic [31:0] hlen, input logic [31:0] plen, input int cut);
        logic [7:0]  frame[$];
        logic [31:0] resv;
        resv = $urandom;
        for (int i = 3; i >= 0; i--) frame.push_back(MAGIC[8*i +: 8]);
        for (int i = 3; i >= 0; i--) frame.push_back(hlen[8*i +: 8]);
        for (int i = 3; i >= 0; i--) frame.push_back(plen[8*i +: 8]);
        for (int i = 3; i >= 0; i--) frame.push_back(resv[8*i +: 8]);
        foreach (body[i]) frame.push_back(body[i]);
        foreach (frame[i]) begin
            if (i == cut) push_byte(8'($urandom), 1'b1);
            push_byte(frame[i], 1'b0);
        end
    endtask

    task automatic send_text_frame(input string s);
        body.delete();
        add_text(s);
        send_frame(EXP_HDR_LEN, body.size(), -1);
    endtask

    // Mostly hex digits of either case, sometimes a neighbor of the digit ranges.
    function automatic logic [7:0] hex_char();
        string digits = "0123456789ABCDEFabcdef";
        string near   = "/:@G`g";
        if ($urandom_range(9) == 0) return near[$urandom_range(5)];
        return digits[$urandom_range(21)];
    endfunction

    task automatic add_token();
        string pwr_args[7] = '{"01", "ON", "00", "STANDBY", "OFF", "QSTN", "0"};
        string lvl_txt;
        case ($urandom_range(9))
            0, 1: begin
                add_text("!1MVL");
                body.push_back(hex_char());
                body.push_back(hex_char());
            end
            2: begin
                // levels around the 200 ceiling or anywhere in the byte range
                lvl_txt = $sformatf("%h", 8'($urandom_range(1) ? $urandom_range(195, 205)
                                                                 : $urandom_range(255)));
                if ($urandom_range(1)) lvl_txt = lvl_txt.toupper();
                add_text("!1MVL");
                add_text(lvl_txt);
            end
            3, 4: begin
                add_text("!1PWR");
                add_text(pwr_args[$urandom_range(6)]);
            end
            5: add_text($urandom_range(1) ? "MV" : "PW");
            6: add_noise($urandom_range(1, 4));
            7: begin
                body.push_back(8'h1A);
                body.push_back(8'h0D);
                body.push_back(8'h0A);
            end
            default: begin
                add_text("!1");
                repeat (3) body.push_back(8'(8'h41 + $urandom_range(25)));
            end
        endcase
    endtask

    task automatic random_frame();
        int unsigned sel;
        int          cut;
        logic [31:0] hlen;
        logic [31:0] plen;
        body.delete();
        repeat ($urandom_range(0, 4)) add_token();
        hlen = EXP_HDR_LEN;
        plen = body.size();
        cut  = ($urandom_range(19) == 0) ? int'($urandom_range(0, 15 + body.size())) : -1;
        sel  = $urandom_range(99);
        if (sel < 8) begin
            // declared longer than sent: the next bytes are eaten as payload
            plen = body.size() + $urandom_range(1, 3);
        end else if (sel < 14) begin
            case ($urandom_range(3))
                0: hlen = 32'd15;
                1: hlen = 32'd17;
                2: hlen = 32'h0000_1000;
                default: hlen = $urandom;
            endcase
        end else if (sel < 24) begin
            // right at the length limit or one past it
            if (max_len <= 13'd64) begin
                while (body.size() > max_len) void'(body.pop_back());
                while (body.size() < max_len) body.push_back(8'($urandom));
                plen = 32'(max_len) + $urandom_range(1);
            end else begin
                plen = 32'(max_len) + 32'd1;
            end
        end else if (sel < 30) begin
            plen = (32'h2000 << $urandom_range(0, 18)) | $urandom_range(0, 255);
        end
        send_frame(hlen, plen, cut);
    endtask

    task automatic fill_random(input int unsigned target);
        int unsigned pick;
        while (bytes_queued < target) begin
            pick = $urandom_range(99);
            if (pick < 80) begin
                random_frame();
            end else if (pick < 90) begin
                repeat ($urandom_range(1, 8)) push_byte(8'($urandom), 1'b0);
            end else if (pick < 95) begin
                push_byte(8'($urandom), 1'b1);
            end else begin
                // header cut short; whatever follows lands in it
                push_text("ISCP");
                repeat ($urandom_range(1, 11)) push_byte(8'($urandom), 1'b0);
            end
        end
    endtask

    // Sender holds off until every byte is taken and every result is back.
    task automatic wait_idle();
        while (bytes_taken != bytes_queued || expected_events.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_max_len(input logic [12:0] v);
        wait_idle();
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        max_len     = v;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic report_mismatch(input string what);
        error_count++;
        $display("[%0t] MISMATCH result %0d: %s", $time, results_seen, what);
    endtask

    // ------------------------------------------------------------------
    // Driver: inputs change on the falling edge
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        t_byte_txn next_byte;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_took) begin
            if (byte_feed.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
                next_byte    = byte_feed.pop_front();
                i_in_valid  <= 1'b1;
                i_data_byte <= next_byte.data;
                i_restart   <= next_byte.restart;
            end else begin
                i_in_valid  <= 1'b0;
                i_data_byte <= 8'($urandom);
                i_restart   <= 1'($urandom);
            end
        end
        i_out_ready <= i_rst_n && (steady || $urandom_range(99) >= IDLE_PCT);
    end

    // ------------------------------------------------------------------
    // Monitor: samples at the rising edge, predicts and checks
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_frame_event exp_ev;
        t_frame_event new_ev;
        logic         hit;
        in_took <= i_in_valid && o_in_ready;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                if (o_event_kind < 3'd6) kind_count[o_event_kind]++;
                if (expected_events.size() == 0) begin
                    report_mismatch($sformatf("kind %0d level %0d with nothing expected",
                                              o_event_kind, o_volume_level));
                end else begin
                    exp_ev = expected_events.pop_front();
                    if (o_event_kind !== exp_ev.kind)
                        report_mismatch($sformatf("event kind %0d, expected %0d",
                                                  o_event_kind, exp_ev.kind));
                    if (o_volume_level !== exp_ev.level)
                        report_mismatch($sformatf("volume level %0d, expected %0d",
                                                  o_volume_level, exp_ev.level));
                end
            end
            if (i_in_valid && o_in_ready) begin
                bytes_taken++;
                parse_byte(i_data_byte, i_restart, hit, new_ev);
                if (hit) expected_events.push_back(new_ev);
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Watchdog: %0d cycles without a transaction, %0d results pending",
                         STALL_LIMIT, expected_events.size());
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        clear_parse_state();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: byte extremes and restarts while hunting
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b1);
        push_byte(8'h00, 1'b1);
        // magic found behind a partial copy of itself
        push_text("ISISC");
        send_text_frame("!1PWR01");
        send_text_frame("!1MVLc8");               // top level 200
        send_text_frame("!1MVLC9");               // 201 is out of range
        send_text_frame("!1MVL0g!1mvl20!1MVL00"); // only the last one counts
        send_text_frame("MVL10");                 // report at the start of the payload
        send_text_frame("!1PWRON");
        send_text_frame("!1PWR00");
        send_text_frame("!1PWRSTANDBY");
        send_text_frame("!1PWROFF");
        send_text_frame("!1PWR00!1PWR01");        // first power report wins
        send_text_frame("!1PWR01!1MVL14");        // volume beats power
        send_text_frame("!1SLI10");               // nothing recognized
        send_text_frame("");                      // empty payload ends at the header
        body.delete();
        send_frame(32'd17, 32'd0, -1);            // bad header length
        send_frame(32'hFFFF_FFFF, 32'd0, -1);
        send_frame(EXP_HDR_LEN, 32'd4097, -1);    // one past the default limit
        send_frame(EXP_HDR_LEN, 32'h0001_0000, -1);
        body.delete();
        add_text("!1PWR01");
        send_frame(EXP_HDR_LEN, body.size(), 18); // restart inside the payload
        send_frame(EXP_HDR_LEN, body.size(), 6);  // restart inside the header
        send_text_frame("!1MVL3A");

        // Random phases over several length limits, zero and the default among them
        fill_random(bytes_queued + 400);
        set_max_len(13'd0);
        fill_random(bytes_queued + 150);
        set_max_len(13'd24);
        fill_random(bytes_queued + 350);
        set_max_len(MAX_LEN_RST);
        steady = 1'b1;
        fill_random(bytes_queued + 200);
        wait_idle();
        steady = 1'b0;
        fill_random(bytes_queued + 200);
        wait_idle();

        $display("Covered %0d byte transactions and %0d result transactions, limits 4096/0/24.",
                 bytes_taken, results_seen);
        $display("Kinds: none %0d, volume %0d, on %0d, standby %0d, bad hdr %0d, too long %0d",
                 kind_count[0], kind_count[1], kind_count[2], kind_count[3],
                 kind_count[4], kind_count[5]);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
src/efp_pkg.sv
src/eiscp_frame_parser_top.sv
tb/tb.sv
